[rtl/core/ipv4_allowlist_with_token_check_defines.svh]
// Assertion macros used by the allowlist sequencer (ialc_ctrl).
`ifndef IPV4_ALLOWLIST_WITH_TOKEN_CHECK_DEFINES_SVH
`define IPV4_ALLOWLIST_WITH_TOKEN_CHECK_DEFINES_SVH

`ifndef ASSERT_OFF

// prop must hold at every clock edge out of reset
`define IALC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("ialc assertion failed");

// prop must never hold
`define IALC_ASSERT_NEVER(lbl, clk, rst_n, prop) \
	`IALC_ASSERT(lbl, clk, rst_n, !(prop))

`else

`define IALC_ASSERT(lbl, clk, rst_n, prop)

`define IALC_ASSERT_NEVER(lbl, clk, rst_n, prop)

`endif

`endif

[rtl/core/ialc_pkg.sv]
// Package: constants, codes and types of the IPv4 allowlist.
package ialc_pkg;

	localparam int TABLE_DEPTH  = 16;
	localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
	localparam int ADDR_W       = 32;
	localparam int TOKEN_W      = 64;
	localparam int ENTRY_W      = 5;
	localparam int STATUS_W     = 3;
	localparam int OP_W         = 2;
	localparam int ALERT_PERIOD = 10;
	localparam int PHASE_W      = $clog2(ALERT_PERIOD);
	localparam int SEED_COUNT   = 2;

	localparam logic [ADDR_W-1:0] SEED_LOOPBACK = 32'h7F00_0001;
	localparam logic [ADDR_W-1:0] SEED_GATEWAY  = 32'h0A00_0001;

	localparam int PADDR_W     = 4;
	localparam int PDATA_W     = 64;
	localparam int REG_SEL_LSB = 3;

	typedef enum logic [0:0] {
		REG_CHECK_ENABLE = 1'b0,
		REG_MASTER_KEY   = 1'b1
	} reg_sel_t;

	typedef enum logic [OP_W-1:0] {
		OP_REGISTER = 2'd0,
		OP_VERIFY   = 2'd1,
		OP_QUERY    = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_ADDED    = 3'd0,
		STAT_PRESENT  = 3'd1,
		STAT_FULL     = 3'd2,
		STAT_UNAUTH   = 3'd3,
		STAT_ALLOWED  = 3'd4,
		STAT_UNLISTED = 3'd5,
		STAT_MISMATCH = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} ctrl_state_t;

	// lookup beat travelling down the cell row
	typedef struct packed {
		logic              vld;
		logic              hit;
		logic [ADDR_W-1:0] addr;
	} probe_t;

	// append command broadcast to the row
	typedef struct packed {
		logic              en;
		logic [CNT_W-1:0]  idx;
		logic [ADDR_W-1:0] data;
	} wr_t;

	// reset content of one cell
	typedef struct packed {
		logic              vld;
		logic [ADDR_W-1:0] addr;
	} seed_t;

endpackage

[rtl/core/ialc_if.sv]
// Request and response channel interfaces.
interface ialc_req_if import ialc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [ADDR_W-1:0]  address;
	logic [TOKEN_W-1:0] token;
	logic               caller_authorized;

	modport source (output valid, output operation, output address, output token,
		output caller_authorized, input ready);
	modport sink (input valid, input operation, input address, input token,
		input caller_authorized, output ready);
endinterface

interface ialc_rsp_if import ialc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                granted;
	logic [STATUS_W-1:0] status;
	logic                raise_alert;
	logic [ENTRY_W-1:0]  entry_count;

	modport source (output valid, output granted, output status, output raise_alert,
		output entry_count, input ready);
	modport sink (input valid, input granted, input status, input raise_alert,
		input entry_count, output ready);
endinterface

[rtl/core/ialc_cell.sv]
// One table cell: holds an entry and compares the passing probe against it.
module ialc_cell import ialc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  seed_t             seed,
	input  logic              we,
	input  logic [ADDR_W-1:0] wdata,
	input  probe_t            probe_i,
	output probe_t            probe_o
);

	logic              valid_q;
	logic [ADDR_W-1:0] entry_q;
	probe_t            probe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= seed.vld;
			entry_q <= seed.addr;
			probe_q <= '0;
		end else begin
			if (we) begin
				valid_q <= 1'b1;
				entry_q <= wdata;
			end
			probe_q.vld  <= probe_i.vld;
			probe_q.addr <= probe_i.addr;
			probe_q.hit  <= probe_i.hit | (valid_q && (entry_q == probe_i.addr));
		end
	end

	assign probe_o = probe_q;

endmodule

[rtl/core/ialc_ctrl.sv]
// Sequencer: takes requests, launches probes, decides and registers results.
`include "ipv4_allowlist_with_token_check_defines.svh"

module ialc_ctrl import ialc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	ialc_req_if.sink           req,
	ialc_rsp_if.source         rsp,
	input  logic               check_en,
	input  logic [TOKEN_W-1:0] master_key,
	output probe_t             probe_o,
	input  probe_t             probe_i,
	output wr_t                wr_o
);

	ctrl_state_t state_q, state_d;

	logic [OP_W-1:0]    op_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [TOKEN_W-1:0] token_q;
	logic               auth_q;
	logic               start_q;
	logic               hit_q;
	logic [CNT_W-1:0]   used_q;
	logic [PHASE_W-1:0] phase_q;

	logic                out_vld_q;
	logic                granted_q;
	status_t             status_q;
	logic                alert_q;
	logic [ENTRY_W-1:0]  count_q;

	logic               accept;
	logic               finish;
	logic               full;
	logic [TOKEN_W-1:0] expected;
	logic [TOKEN_W-1:0] presented;
	logic               res_granted;
	status_t            res_status;
	logic               res_alert;
	logic               do_write;
	logic               do_mismatch;
	logic [CNT_W-1:0]   used_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		finish  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (probe_i.vld) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_vld_q || rsp.ready) begin
					finish  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	assign full      = (used_q >= CNT_W'(TABLE_DEPTH));
	assign expected  = {addr_q, {ADDR_W{1'b0}}} ^ master_key;
	assign presented = (op_q == OP_VERIFY) ? token_q : expected;

	always_comb begin
		res_granted = 1'b0;
		res_status  = STAT_UNLISTED;
		res_alert   = 1'b0;
		do_write    = 1'b0;
		do_mismatch = 1'b0;
		unique case (op_q)
			OP_REGISTER: begin
				priority if (full) begin
					res_status = STAT_FULL;
				end else if (!auth_q) begin
					res_status = STAT_UNAUTH;
				end else if (hit_q) begin
					res_granted = 1'b1;
					res_status  = STAT_PRESENT;
				end else begin
					res_granted = 1'b1;
					res_status  = STAT_ADDED;
					do_write    = 1'b1;
				end
			end
			OP_VERIFY, OP_QUERY: begin
				if (check_en && hit_q) begin
					if (addr_q == SEED_LOOPBACK || addr_q == SEED_GATEWAY ||
						presented == expected) begin
						res_granted = 1'b1;
						res_status  = STAT_ALLOWED;
					end else begin
						res_status  = STAT_MISMATCH;
						res_alert   = (phase_q == '0);
						do_mismatch = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	assign used_next = do_write ? used_q + 1'b1 : used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= 1'b0;
			hit_q     <= 1'b0;
			used_q    <= CNT_W'(SEED_COUNT);
			phase_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			start_q <= accept;
			if (state_q == S_SCAN && probe_i.vld) begin
				hit_q <= probe_i.hit;
			end
			if (finish) begin
				out_vld_q <= 1'b1;
				used_q    <= used_next;
				if (do_mismatch) begin
					phase_q <= (phase_q == PHASE_W'(ALERT_PERIOD - 1)) ? '0 : phase_q + 1'b1;
				end
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.operation;
			addr_q  <= req.address;
			token_q <= req.token;
			auth_q  <= req.caller_authorized;
		end
		if (finish) begin
			granted_q <= res_granted;
			status_q  <= res_status;
			alert_q   <= res_alert;
			count_q   <= ENTRY_W'(used_next);
		end
	end

	assign probe_o.vld  = start_q;
	assign probe_o.hit  = 1'b0;
	assign probe_o.addr = addr_q;

	assign wr_o.en   = finish && do_write;
	assign wr_o.idx  = used_q;
	assign wr_o.data = addr_q;

	assign rsp.valid       = out_vld_q;
	assign rsp.granted     = granted_q;
	assign rsp.status      = status_q;
	assign rsp.raise_alert = alert_q;
	assign rsp.entry_count = count_q;

	`IALC_ASSERT(a_used_bound, clk, arst_n, used_q <= CNT_W'(TABLE_DEPTH))
	`IALC_ASSERT(a_phase_bound, clk, arst_n, phase_q < PHASE_W'(ALERT_PERIOD))
	`IALC_ASSERT(a_tail_in_scan, clk, arst_n, probe_i.vld |-> state_q == S_SCAN)
	`IALC_ASSERT_NEVER(a_write_when_full, clk, arst_n, wr_o.en && full)
	`IALC_ASSERT(a_alert_on_mismatch, clk, arst_n, rsp.valid && rsp.raise_alert |-> rsp.status == STAT_MISMATCH)

endmodule

[rtl/core/ipv4_allowlist_with_token_check.sv]
// Top level: IPv4 allowlist built as a row of compare cells, with APB registers.
//
//  channel | dir | handshake     | beat
//  --------+-----+---------------+---------------------------------------------
//  req     | in  | valid/ready   | operation, address, token, caller_authorized
//  rsp     | out | valid/ready   | granted, status, raise_alert, entry_count
//  apb     | in  | psel/penable  | check_enable at 0x0, master_key at 0x8
//
// One request at a time: the next accept waits until the probe has walked the
// cell row one cell per clock and the result has been registered.
// Reset seeds cells 0 and 1; no clearing pass, requests taken right after reset.
// A stalled rsp holds the result; the next request is still taken and waits in
// its final step until the output register frees.
module ipv4_allowlist_with_token_check import ialc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	ialc_req_if.sink           req,
	ialc_rsp_if.source         rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic               check_en_q;
	logic [TOKEN_W-1:0] key_q;
	reg_sel_t           reg_sel;

	probe_t chain [TABLE_DEPTH+1];
	wr_t    wr;

	assign reg_sel = reg_sel_t'(paddr[REG_SEL_LSB]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_en_q <= 1'b1;
			key_q      <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				REG_CHECK_ENABLE: check_en_q <= pwdata[0];
				REG_MASTER_KEY:   key_q      <= TOKEN_W'(pwdata);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_CHECK_ENABLE: prdata = PDATA_W'(check_en_q);
			REG_MASTER_KEY:   prdata = PDATA_W'(key_q);
			default:          prdata = '0;
		endcase
	end

	ialc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.check_en   (check_en_q),
		.master_key (key_q),
		.probe_o    (chain[0]),
		.probe_i    (chain[TABLE_DEPTH]),
		.wr_o       (wr)
	);

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		seed_t seed;
		logic  we;

		if (i == 0) begin : g_loopback
			assign seed = '{vld: 1'b1, addr: SEED_LOOPBACK};
		end else if (i == 1) begin : g_gateway
			assign seed = '{vld: 1'b1, addr: SEED_GATEWAY};
		end else begin : g_empty
			assign seed = '0;
		end

		assign we = wr.en && (wr.idx == CNT_W'(i));

		ialc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.seed    (seed),
			.we      (we),
			.wdata   (wr.data),
			.probe_i (chain[i]),
			.probe_o (chain[i+1])
		);
	end

endmodule
